[rtl/bpfl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types and codes for the buffer pool free list: operation codes,
// result status codes, configuration register indexes and reset values, controller states.
// ----------------------------------------------------------------------------
package bpfl_pkg;

	localparam int BASE_W  = 32;
	localparam int SIZE_W  = 16;
	localparam int COUNT_W = 9;

	localparam logic [BASE_W-1:0]  RST_POOL_BASE    = 32'd0;
	localparam logic [SIZE_W-1:0]  RST_BUFFER_SIZE  = 16'd2048;
	localparam logic [COUNT_W-1:0] RST_BUFFER_COUNT = 9'd256;
	localparam logic [SIZE_W-1:0]  RST_OFFSET_BYTES = 16'd0;

	typedef enum logic [1:0] {
		OP_GET_RAW,
		OP_GET_OFS,
		OP_REL_RAW,
		OP_REL_OFS
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EMPTY,
		STAT_IGNORED,
		STAT_FULL
	} status_t;

	typedef enum logic [1:0] {
		REG_POOL_BASE,
		REG_BUFFER_SIZE,
		REG_BUFFER_COUNT,
		REG_OFFSET_BYTES
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_FILL,
		S_IDLE,
		S_GET,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/bpfl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpfl_ram
// Free queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpfl_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/bpfl_mod.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpfl_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle, flags a
// zero remainder when done pulses.
// ----------------------------------------------------------------------------
module bpfl_mod #(
	parameter int DVD_W = 25
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [15:0]      divisor,
	output logic                  done,
	output logic                  rem_zero
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [15:0]      rem_q;
	logic [16:0]      trial;
	logic [16:0]      diff;
	logic [15:0]      rem_n;

	// partial remainder stays below the divisor, so the difference fits 16 bits
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, divisor};
		rem_n = (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

[rtl/buffer_pool_free_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_pool_free_list
// get: out_valid after S_GET, S_DONE and the output register, with the queue
//   memory read data registered; a release that fails the span, offset or length check goes from S_CHECK to S_DONE
// release: S_CHECK, S_DIV and S_DONE before out_valid; S_DIV waits on the bit-serial
//   start-alignment remainder over a SPAN_W-bit dividend, SPAN_W = clog2(MAX_BUFFERS+1) + 16
// one item in flight; in_ready rises in the same cycle as out_valid, so the next
//   beat can be taken while the result waits in the output reg
// reset and every config write refill the queue with used-count buffer starts,
//   with in_ready low, one start written per cycle
// ----------------------------------------------------------------------------
module buffer_pool_free_list #(
	parameter int MAX_BUFFERS = 256,
	parameter int ADDR_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] release_address,
	input  wire logic [15:0] release_length,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      granted_address,
	output logic [1:0]       status,
	output logic [8:0]       free_count
);

	localparam int IDX_W  = $clog2(MAX_BUFFERS);
	localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
	// pool span is used count times a 16-bit buffer size
	localparam int SPAN_W = CNT_W + 16;
	localparam int CMP_W  = (ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W;

	// configuration registers
	logic [31:0] pool_base_q;
	logic [15:0] buffer_size_q;
	logic [8:0]  buffer_count_q;
	logic [15:0] offset_bytes_q;

	bpfl_pkg::state_t state_q, state_d;

	// refill sweep: index and running offset index*buffer_size
	logic [CNT_W-1:0]  fill_idx_q;
	logic [SPAN_W-1:0] fill_acc_q;
	logic [SPAN_W-1:0] span_q;

	// queue pointers
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] fill_q;

	// item in flight
	bpfl_pkg::op_t          op_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic [15:0]            len_s1;
	logic [ADDR_BITS-1:0]   push_s2;
	logic [31:0]            res_grant_q;
	bpfl_pkg::status_t      res_status_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_grant_q;
	logic [1:0]  out_status_q;
	logic [8:0]  out_count_q;

	// memory and remainder unit hookup
	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ADDR_BITS-1:0] ram_wdata;
	logic [ADDR_BITS-1:0] ram_rdata;
	logic                 div_start, div_done, div_rem_zero;
	logic [SPAN_W-1:0]    div_dividend;

	// derived values
	logic [ADDR_BITS-1:0] base_a;
	logic [CNT_W-1:0]     used_n;
	logic [ADDR_BITS-1:0] rel_dist;
	logic [ADDR_BITS-1:0] dist_ofs;
	logic                 in_span;
	logic                 pre_ok;
	logic                 fill_done;
	logic                 queue_full;
	logic                 out_free;
	logic [IDX_W-1:0]     head_next, tail_next;
	logic [ADDR_BITS-1:0] get_addr;

	assign base_a     = ADDR_BITS'(pool_base_q);
	assign fill_done  = (fill_idx_q == used_n);
	assign queue_full = (fill_q == CNT_W'(MAX_BUFFERS));
	assign out_free   = !out_valid_q || out_ready;
	assign head_next  = (head_q == IDX_W'(MAX_BUFFERS - 1)) ? '0 : head_q + 1'b1;
	assign tail_next  = (tail_q == IDX_W'(MAX_BUFFERS - 1)) ? '0 : tail_q + 1'b1;

	// buffers in use: zero size empties the pool, count clips at the queue depth
	always_comb begin
		if (buffer_size_q == '0) begin
			used_n = '0;
		end else if (int'(buffer_count_q) > MAX_BUFFERS) begin
			used_n = CNT_W'(MAX_BUFFERS);
		end else begin
			used_n = CNT_W'(buffer_count_q);
		end
	end

	// release checks, everything modulo 2^ADDR_BITS
	always_comb begin
		rel_dist = addr_s1 - base_a;
		dist_ofs = rel_dist - ADDR_BITS'(offset_bytes_q);
		in_span  = (buffer_size_q != '0) && (CMP_W'(rel_dist) < CMP_W'(span_q));
		if (op_s1 == bpfl_pkg::OP_REL_RAW) begin
			pre_ok       = (len_s1 == buffer_size_q);
			div_dividend = SPAN_W'(rel_dist);
		end else begin
			pre_ok       = (rel_dist >= ADDR_BITS'(offset_bytes_q))
			               && (offset_bytes_q <= buffer_size_q)
			               && (len_s1 == buffer_size_q - offset_bytes_q);
			div_dividend = SPAN_W'(dist_ofs);
		end
	end

	assign get_addr = (op_s1 == bpfl_pkg::OP_GET_OFS)
	                  ? ram_rdata + ADDR_BITS'(offset_bytes_q) : ram_rdata;

	// controller: next state, handshake and memory strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = push_s2;
		div_start = 1'b0;
		case (state_q)
			bpfl_pkg::S_FILL: begin
				if (fill_done) begin
					state_d = bpfl_pkg::S_IDLE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = fill_idx_q[IDX_W-1:0];
					ram_wdata = base_a + ADDR_BITS'(fill_acc_q);
				end
			end
			bpfl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// head read issued now, data lands in S_GET
					ram_re = 1'b1;
					if (opcode inside {bpfl_pkg::OP_GET_RAW, bpfl_pkg::OP_GET_OFS}) begin
						state_d = bpfl_pkg::S_GET;
					end else begin
						state_d = bpfl_pkg::S_CHECK;
					end
				end
			end
			bpfl_pkg::S_GET: begin
				state_d = bpfl_pkg::S_DONE;
			end
			bpfl_pkg::S_CHECK: begin
				if (in_span && pre_ok) begin
					div_start = 1'b1;
					state_d   = bpfl_pkg::S_DIV;
				end else begin
					state_d = bpfl_pkg::S_DONE;
				end
			end
			bpfl_pkg::S_DIV: begin
				if (div_done) begin
					ram_we  = div_rem_zero && !queue_full;
					state_d = bpfl_pkg::S_DONE;
				end
			end
			bpfl_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bpfl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfl_pkg::S_FILL;
			end
		endcase
		// any register write rebuilds the queue
		if (cfg_we) begin
			state_d = bpfl_pkg::S_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfl_pkg::S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, refill sweep and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q    <= bpfl_pkg::RST_POOL_BASE;
			buffer_size_q  <= bpfl_pkg::RST_BUFFER_SIZE;
			buffer_count_q <= bpfl_pkg::RST_BUFFER_COUNT;
			offset_bytes_q <= bpfl_pkg::RST_OFFSET_BYTES;
			fill_idx_q     <= '0;
			fill_acc_q     <= '0;
			span_q         <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			fill_q         <= '0;
		end else if (cfg_we) begin
			case (bpfl_pkg::reg_idx_t'(cfg_index))
				bpfl_pkg::REG_POOL_BASE:    pool_base_q    <= cfg_wdata;
				bpfl_pkg::REG_BUFFER_SIZE:  buffer_size_q  <= cfg_wdata[15:0];
				bpfl_pkg::REG_BUFFER_COUNT: buffer_count_q <= cfg_wdata[8:0];
				bpfl_pkg::REG_OFFSET_BYTES: offset_bytes_q <= cfg_wdata[15:0];
				default: ;
			endcase
			fill_idx_q <= '0;
			fill_acc_q <= '0;
		end else begin
			case (state_q)
				bpfl_pkg::S_FILL: begin
					if (fill_done) begin
						// sweep end: accumulator holds used*size, the pool span
						head_q <= '0;
						tail_q <= (fill_idx_q == CNT_W'(MAX_BUFFERS))
						          ? '0 : fill_idx_q[IDX_W-1:0];
						fill_q <= fill_idx_q;
						span_q <= fill_acc_q;
					end else begin
						fill_idx_q <= fill_idx_q + 1'b1;
						fill_acc_q <= fill_acc_q + SPAN_W'(buffer_size_q);
					end
				end
				bpfl_pkg::S_GET: begin
					if (fill_q != '0) begin
						head_q <= head_next;
						fill_q <= fill_q - 1'b1;
					end
				end
				bpfl_pkg::S_DIV: begin
					if (div_done && div_rem_zero && !queue_full) begin
						tail_q <= tail_next;
						fill_q <= fill_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bpfl_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (state_q == bpfl_pkg::S_IDLE && in_valid) begin
			op_s1   <= bpfl_pkg::op_t'(opcode);
			addr_s1 <= ADDR_BITS'(release_address);
			len_s1  <= release_length;
		end
		case (state_q)
			bpfl_pkg::S_GET: begin
				if (fill_q == '0) begin
					res_grant_q  <= '0;
					res_status_q <= bpfl_pkg::STAT_EMPTY;
				end else begin
					res_grant_q  <= 32'(get_addr);
					res_status_q <= bpfl_pkg::STAT_OK;
				end
			end
			bpfl_pkg::S_CHECK: begin
				res_grant_q  <= '0;
				res_status_q <= bpfl_pkg::STAT_IGNORED;
				push_s2      <= (op_s1 == bpfl_pkg::OP_REL_RAW)
				                ? addr_s1 : addr_s1 - ADDR_BITS'(offset_bytes_q);
			end
			bpfl_pkg::S_DIV: begin
				if (div_done) begin
					if (!div_rem_zero) begin
						res_status_q <= bpfl_pkg::STAT_IGNORED;
					end else if (queue_full) begin
						res_status_q <= bpfl_pkg::STAT_FULL;
					end else begin
						res_status_q <= bpfl_pkg::STAT_OK;
					end
				end
			end
			bpfl_pkg::S_DONE: begin
				if (out_free) begin
					out_grant_q  <= res_grant_q;
					out_status_q <= res_status_q;
					out_count_q  <= 9'(fill_q);
				end
			end
			default: ;
		endcase
	end

	bpfl_ram #(
		.DEPTH (MAX_BUFFERS),
		.WIDTH (ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// buffer start alignment: (distance from base, less offset_bytes for an offset release) mod buffer_size
	bpfl_mod #(
		.DVD_W (SPAN_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (buffer_size_q),
		.done     (div_done),
		.rem_zero (div_rem_zero)
	);

	assign out_valid       = out_valid_q;
	assign granted_address = out_grant_q;
	assign status          = out_status_q;
	assign free_count      = out_count_q;

endmodule
`default_nettype wire

[rtl/bpfl_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpfl_checker
// Port-level checks on the buffer pool free list, bound to the top level.
// ----------------------------------------------------------------------------
module bpfl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] granted_address,
	input wire logic [1:0]  status,
	input wire logic [8:0]  free_count
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_address)
		&& $stable(status) && $stable(free_count))
		else $error("result beat changed while stalled");

	// only a successful get hands out an address
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bpfl_pkg::STAT_OK |-> granted_address == '0)
		else $error("address granted on a failed operation");

	// empty report goes with an empty queue
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bpfl_pkg::STAT_EMPTY |-> free_count == '0)
		else $error("pool empty reported with buffers left");

	// one item at a time: an accepted beat closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

endmodule

bind buffer_pool_free_list bpfl_checker u_bpfl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.granted_address (granted_address),
	.status          (status),
	.free_count      (free_count)
);
`default_nettype wire
